[rtl/core/assert_macros.svh]
// Assertion macros shared by the clip unit modules.
// Each macro expects clk_i and rst_ni to exist in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define ASSERT_RST(lbl, prop, msg)
`define ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

[rtl/core/lswc_pkg.sv]
package lswc_pkg;

  localparam int unsigned CB = 16;
  localparam int unsigned LAT = CB + 1;
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEFT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_BOTTOM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_RIGHT  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TOP    = 2'd3;

  localparam int unsigned RGN_LEFT  = 0;
  localparam int unsigned RGN_RIGHT = 1;
  localparam int unsigned RGN_BELOW = 2;
  localparam int unsigned RGN_ABOVE = 3;

  typedef logic signed [CB-1:0] coord_t;
  typedef logic signed [CB:0]   diff_t;
  typedef logic signed [CB+1:0] wide_t;
  typedef logic [CB-1:0]        mag_t;
  typedef logic [3:0]           region_t;

  localparam coord_t WIN_LEFT_RST   = coord_t'(100);
  localparam coord_t WIN_BOTTOM_RST = coord_t'(100);
  localparam coord_t WIN_RIGHT_RST  = coord_t'(300);
  localparam coord_t WIN_TOP_RST    = coord_t'(300);

  typedef struct packed {
    coord_t left;
    coord_t bottom;
    coord_t right;
    coord_t top;
  } lswc_window_t;

  typedef struct packed {
    coord_t  ax;
    coord_t  ay;
    coord_t  bx;
    coord_t  by;
    region_t ca;
    region_t cb;
    logic    reject;
  } lswc_job_t;

  typedef struct packed {
    wide_t x;
    wide_t y;
  } lswc_point_t;

  function automatic region_t region_f(input coord_t x, input coord_t y,
                                       input lswc_window_t w);
    region_t c;
    c = '0;
    c[RGN_LEFT]  = x < w.left;
    c[RGN_RIGHT] = x > w.right;
    c[RGN_BELOW] = y < w.bottom;
    c[RGN_ABOVE] = y > w.top;
    return c;
  endfunction

  function automatic mag_t mag_f(input diff_t v);
    diff_t n;
    n = -v;
    return v[CB] ? n[CB-1:0] : v[CB-1:0];
  endfunction

endpackage

[rtl/core/lswc_muldiv.sv]
module lswc_muldiv (
  input  logic           clk_i,
  input  logic           en_i,
  input  lswc_pkg::mag_t a_i,
  input  lswc_pkg::mag_t b_i,
  input  lswc_pkg::mag_t c_i,
  input  logic           neg_i,
  output lswc_pkg::diff_t q_o
);
  import lswc_pkg::*;

  logic [2*CB-1:0] prod_q;
  mag_t            c0_q;
  logic            neg0_q;

  mag_t rem_q [CB];
  mag_t lo_q  [CB];
  mag_t quo_q [CB];
  mag_t div_q [CB];
  logic sgn_q [CB];

  mag_t rem_d [CB];
  mag_t lo_d  [CB];
  mag_t quo_d [CB];

  mag_t rem_in [CB];
  mag_t lo_in  [CB];
  mag_t quo_in [CB];
  mag_t div_in [CB];

  always_comb begin
    logic [CB:0] t;
    logic        ge;
    rem_in[0] = prod_q[2*CB-1:CB];
    lo_in[0]  = prod_q[CB-1:0];
    quo_in[0] = '0;
    div_in[0] = c0_q;
    for (int s = 1; s < CB; s++) begin
      rem_in[s] = rem_q[s-1];
      lo_in[s]  = lo_q[s-1];
      quo_in[s] = quo_q[s-1];
      div_in[s] = div_q[s-1];
    end
    for (int s = 0; s < CB; s++) begin
      t  = {rem_in[s], lo_in[s][CB-1]};
      ge = t >= {1'b0, div_in[s]};
      rem_d[s] = ge ? CB'(t - {1'b0, div_in[s]}) : t[CB-1:0];
      lo_d[s]  = {lo_in[s][CB-2:0], 1'b0};
      quo_d[s] = {quo_in[s][CB-2:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q   <= (2*CB)'(a_i) * (2*CB)'(b_i);
      c0_q     <= c_i;
      neg0_q   <= neg_i;
      div_q[0] <= c0_q;
      sgn_q[0] <= neg0_q;
      for (int s = 0; s < CB; s++) begin
        rem_q[s] <= rem_d[s];
        lo_q[s]  <= lo_d[s];
        quo_q[s] <= quo_d[s];
      end
      for (int s = 1; s < CB; s++) begin
        div_q[s] <= div_q[s-1];
        sgn_q[s] <= sgn_q[s-1];
      end
    end
  end

  assign q_o = sgn_q[CB-1] ? -diff_t'({1'b0, quo_q[CB-1]}) : diff_t'({1'b0, quo_q[CB-1]});

endmodule

[rtl/core/lswc_front.sv]
`include "assert_macros.svh"

module lswc_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lswc_pkg::lswc_window_t win_i,
  input  logic                 push_i,
  output logic                 full_o,
  input  lswc_pkg::coord_t     start_x_i,
  input  lswc_pkg::coord_t     start_y_i,
  input  lswc_pkg::coord_t     end_x_i,
  input  lswc_pkg::coord_t     end_y_i,
  input  logic                 q_pop_i,
  output logic                 q_empty_o,
  output lswc_pkg::lswc_job_t  q_job_o
);
  import lswc_pkg::*;

  lswc_job_t         mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QPTR_W:0]   cnt_q, cnt_d;
  lswc_job_t         job;
  logic              push_ok;

  always_comb begin
    job.ax = start_x_i;
    job.ay = start_y_i;
    job.bx = end_x_i;
    job.by = end_y_i;
    job.ca = region_f(start_x_i, start_y_i, win_i);
    job.cb = region_f(end_x_i, end_y_i, win_i);
    job.reject = |(job.ca & job.cb);
  end

  assign full_o    = cnt_q == (QPTR_W+1)'(QDEPTH);
  assign q_empty_o = cnt_q == '0;
  assign push_ok   = push_i && !full_o;
  assign q_job_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_ok) begin
      wr_d = (wr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (q_pop_i) begin
      rd_d = (rd_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_ok && !q_pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_ok && q_pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wr_q] <= job;
    end
  end

  `ASSERT_RST(a_cnt_bound, cnt_q <= (QPTR_W+1)'(QDEPTH), "queue count exceeds depth")
  `ASSERT_RST(a_pop_nonempty, q_pop_i |-> cnt_q != '0, "queue popped while empty")
  `ASSERT_RST(a_push_grows, (push_ok && !q_pop_i) |=> cnt_q == $past(cnt_q) + 1'b1,
              "queue count did not grow on push")

endmodule

[rtl/core/lswc_back.sv]
`include "assert_macros.svh"

module lswc_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  lswc_pkg::lswc_window_t win_i,
  input  logic                   job_valid_i,
  input  lswc_pkg::lswc_job_t    job_i,
  output logic                   job_pop_o,
  output logic                   empty_o,
  input  logic                   pop_i,
  output logic                   visible_o,
  output lswc_pkg::coord_t       clip_start_x_o,
  output lswc_pkg::coord_t       clip_start_y_o,
  output lswc_pkg::coord_t       clip_end_x_o,
  output lswc_pkg::coord_t       clip_end_y_o,
  output lswc_pkg::region_t      start_region_o,
  output lswc_pkg::region_t      end_region_o
);
  import lswc_pkg::*;

  logic      adv;
  diff_t     dx, dy, ha, va, hb, vb;
  mag_t      op_a [4];
  mag_t      op_b [4];
  mag_t      op_c [4];
  logic      op_n [4];
  diff_t     quo  [4];
  lswc_job_t job_q [LAT];
  logic      v_q   [LAT];
  lswc_job_t jt;
  lswc_point_t pa, pb;
  logic      vis;
  logic      out_v_q;
  logic      vis_q;
  coord_t    sx_q, sy_q, ex_q, ey_q;
  region_t   sr_q, er_q;

  function automatic lswc_point_t move_f(input coord_t x, input coord_t y,
                                         input region_t code, input diff_t qh,
                                         input diff_t qv, input lswc_window_t w);
    lswc_point_t p;
    wide_t       xn, yn;
    coord_t      ye, xe;
    logic        beyond;
    xn = wide_t'(x) + wide_t'(qh);
    yn = wide_t'(y) + wide_t'(qv);
    ye = code[RGN_BELOW] ? w.bottom : w.top;
    xe = code[RGN_LEFT] ? w.left : w.right;
    beyond = code[RGN_LEFT] ? (xn < wide_t'(w.left)) : (xn > wide_t'(w.right));
    if ((code[RGN_BELOW] || code[RGN_ABOVE]) &&
        (!(code[RGN_LEFT] || code[RGN_RIGHT]) || !beyond)) begin
      p.x = xn;
      p.y = wide_t'(ye);
    end else if (code[RGN_LEFT] || code[RGN_RIGHT]) begin
      p.x = wide_t'(xe);
      p.y = yn;
    end else begin
      p.x = wide_t'(x);
      p.y = wide_t'(y);
    end
    return p;
  endfunction

  function automatic logic in_win_f(input lswc_point_t p, input lswc_window_t w);
    return p.x >= wide_t'(w.left) && p.x <= wide_t'(w.right) &&
           p.y >= wide_t'(w.bottom) && p.y <= wide_t'(w.top);
  endfunction

  assign adv       = !out_v_q || pop_i;
  assign job_pop_o = adv && job_valid_i;
  assign empty_o   = !out_v_q;

  always_comb begin
    dx = diff_t'(job_i.bx) - diff_t'(job_i.ax);
    dy = diff_t'(job_i.by) - diff_t'(job_i.ay);
    ha = diff_t'(job_i.ca[RGN_BELOW] ? win_i.bottom : win_i.top) - diff_t'(job_i.ay);
    va = diff_t'(job_i.ca[RGN_LEFT] ? win_i.left : win_i.right) - diff_t'(job_i.ax);
    hb = diff_t'(job_i.cb[RGN_BELOW] ? win_i.bottom : win_i.top) - diff_t'(job_i.by);
    vb = diff_t'(job_i.cb[RGN_LEFT] ? win_i.left : win_i.right) - diff_t'(job_i.bx);
    op_a[0] = mag_f(ha); op_b[0] = mag_f(dx); op_c[0] = mag_f(dy);
    op_n[0] = ha[CB] ^ dx[CB] ^ dy[CB];
    op_a[1] = mag_f(va); op_b[1] = mag_f(dy); op_c[1] = mag_f(dx);
    op_n[1] = va[CB] ^ dy[CB] ^ dx[CB];
    op_a[2] = mag_f(hb); op_b[2] = mag_f(dx); op_c[2] = mag_f(dy);
    op_n[2] = hb[CB] ^ dx[CB] ^ dy[CB];
    op_a[3] = mag_f(vb); op_b[3] = mag_f(dy); op_c[3] = mag_f(dx);
    op_n[3] = vb[CB] ^ dy[CB] ^ dx[CB];
  end

  for (genvar g = 0; g < 4; g++) begin : g_lane
    lswc_muldiv u_muldiv (
      .clk_i (clk_i),
      .en_i  (adv),
      .a_i   (op_a[g]),
      .b_i   (op_b[g]),
      .c_i   (op_c[g]),
      .neg_i (op_n[g]),
      .q_o   (quo[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < LAT; s++) begin
        v_q[s] <= 1'b0;
      end
      out_v_q <= 1'b0;
    end else if (adv) begin
      v_q[0] <= job_valid_i;
      for (int s = 1; s < LAT; s++) begin
        v_q[s] <= v_q[s-1];
      end
      out_v_q <= v_q[LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      job_q[0] <= job_i;
      for (int s = 1; s < LAT; s++) begin
        job_q[s] <= job_q[s-1];
      end
    end
  end

  always_comb begin
    jt  = job_q[LAT-1];
    pa  = move_f(jt.ax, jt.ay, jt.ca, quo[0], quo[1], win_i);
    pb  = move_f(jt.bx, jt.by, jt.cb, quo[2], quo[3], win_i);
    vis = !jt.reject && in_win_f(pa, win_i) && in_win_f(pb, win_i);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      vis_q <= vis;
      sx_q  <= vis ? pa.x[CB-1:0] : '0;
      sy_q  <= vis ? pa.y[CB-1:0] : '0;
      ex_q  <= vis ? pb.x[CB-1:0] : '0;
      ey_q  <= vis ? pb.y[CB-1:0] : '0;
      sr_q  <= jt.ca;
      er_q  <= jt.cb;
    end
  end

  assign visible_o      = vis_q;
  assign clip_start_x_o = sx_q;
  assign clip_start_y_o = sy_q;
  assign clip_end_x_o   = ex_q;
  assign clip_end_y_o   = ey_q;
  assign start_region_o = sr_q;
  assign end_region_o   = er_q;

  `ASSERT_RST(a_vis_codes, (out_v_q && vis_q) |-> (sr_q & er_q) == '0,
              "visible item with shared region bits")
  `ASSERT_RST(a_vis_in_win, (out_v_q && vis_q) |->
              (sx_q >= win_i.left && sx_q <= win_i.right &&
               ey_q >= win_i.bottom && ey_q <= win_i.top),
              "visible item outside window")
  `ASSERT_RST(a_rej_zero, (out_v_q && !vis_q) |->
              (sx_q == '0 && sy_q == '0 && ex_q == '0 && ey_q == '0),
              "rejected item with nonzero coordinates")

endmodule

[rtl/core/line_segment_window_clip_unit.sv]
// Clips one line segment per item to the window held in four configuration registers,
// with window edges inclusive. The unit takes one item per clock cycle when the result
// side keeps popping; an item's result comes from the four one-bit-per-stage crossing
// dividers in the back pipeline. A four-entry queue between the region coder and the
// divider pipeline absorbs result-side stalls; while a result waits unpopped in the
// result register, the whole back pipeline holds and no new item enters it.
module line_segment_window_clip_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [lswc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  lswc_pkg::coord_t           cfg_wdata_i,
  input  logic                       push,
  output logic                       full,
  input  lswc_pkg::coord_t           start_x_i,
  input  lswc_pkg::coord_t           start_y_i,
  input  lswc_pkg::coord_t           end_x_i,
  input  lswc_pkg::coord_t           end_y_i,
  output logic                       empty,
  input  logic                       pop,
  output logic                       visible_o,
  output lswc_pkg::coord_t           clip_start_x_o,
  output lswc_pkg::coord_t           clip_start_y_o,
  output lswc_pkg::coord_t           clip_end_x_o,
  output lswc_pkg::coord_t           clip_end_y_o,
  output lswc_pkg::region_t          start_region_o,
  output lswc_pkg::region_t          end_region_o
);
  import lswc_pkg::*;

  lswc_window_t win_q;
  logic         q_pop;
  logic         q_empty;
  lswc_job_t    q_job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q.left   <= WIN_LEFT_RST;
      win_q.bottom <= WIN_BOTTOM_RST;
      win_q.right  <= WIN_RIGHT_RST;
      win_q.top    <= WIN_TOP_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_WINDOW_LEFT:   win_q.left   <= cfg_wdata_i;
        REG_WINDOW_BOTTOM: win_q.bottom <= cfg_wdata_i;
        REG_WINDOW_RIGHT:  win_q.right  <= cfg_wdata_i;
        REG_WINDOW_TOP:    win_q.top    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  lswc_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .win_i     (win_q),
    .push_i    (push),
    .full_o    (full),
    .start_x_i (start_x_i),
    .start_y_i (start_y_i),
    .end_x_i   (end_x_i),
    .end_y_i   (end_y_i),
    .q_pop_i   (q_pop),
    .q_empty_o (q_empty),
    .q_job_o   (q_job)
  );

  lswc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .win_i          (win_q),
    .job_valid_i    (!q_empty),
    .job_i          (q_job),
    .job_pop_o      (q_pop),
    .empty_o        (empty),
    .pop_i          (pop),
    .visible_o      (visible_o),
    .clip_start_x_o (clip_start_x_o),
    .clip_start_y_o (clip_start_y_o),
    .clip_end_x_o   (clip_end_x_o),
    .clip_end_y_o   (clip_end_y_o),
    .start_region_o (start_region_o),
    .end_region_o   (end_region_o)
  );

endmodule
